// ===== rtl/cara_pkg.sv =====
// Shared types, register indexes and constants of the circle arc rasterizer.
`timescale 1ns / 1ps

package cara_pkg;

   // Loop limits
   localparam int CARA_MAX_RADIUS_DEF = 63;
   localparam int CARA_MAX_STEPS      = 46;

   // Field widths
   localparam int CARA_COL_W    = 7;
   localparam int CARA_ROW_W    = 6;
   localparam int CARA_OFS_W    = 7;
   localparam int CARA_OUT_OFS_W = 6;
   localparam int CARA_RADIUS_W = 6;
   localparam int CARA_MASK_W   = 8;

   // Register reset values
   localparam logic [CARA_RADIUS_W-1:0] CARA_RADIUS_RST     = 6'd15;
   localparam logic [CARA_ROW_W-1:0]    CARA_CENTER_ROW_RST = 6'd36;

   // Decision variable constants of the midpoint walk
   localparam int CARA_DEC_INIT     = 3;
   localparam int CARA_DEC_INC_LOW  = 6;
   localparam int CARA_DEC_INC_HIGH = 10;

   // Quadrant codes, clockwise from top-right
   localparam logic [1:0] CARA_QUAD_TR = 2'd0;
   localparam logic [1:0] CARA_QUAD_BR = 2'd1;
   localparam logic [1:0] CARA_QUAD_BL = 2'd2;
   localparam logic [1:0] CARA_QUAD_TL = 2'd3;

   // Register indexes
   typedef logic [0:0] csr_index_type;
   localparam csr_index_type CARA_CSR_RADIUS     = 1'b0;
   localparam csr_index_type CARA_CSR_CENTER_ROW = 1'b1;

   // Controller states
   typedef enum logic [0:0] {
      CARA_IDLE,
      CARA_RUN
   } cara_state_type;

   // Controller to datapath
   typedef struct packed {
      logic load;
      logic step;
   } cara_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic out_free;
      logic done;
   } cara_sts_type;

endpackage

// ===== rtl/cara_req_if.sv =====
// Arc command channel.
`timescale 1ns / 1ps

interface cara_req_if import cara_pkg::*; ();
   logic                         valid;
   logic                         ready;
   logic [CARA_COL_W-1:0]        center_col;
   logic signed [CARA_OFS_W-1:0] start_dx;
   logic signed [CARA_OFS_W-1:0] start_dy;
   logic [1:0]                   start_quadrant;
   logic signed [CARA_OFS_W-1:0] end_dx;
   logic signed [CARA_OFS_W-1:0] end_dy;
   logic [1:0]                   end_quadrant;

   modport source (
      output valid, center_col, start_dx, start_dy, start_quadrant,
             end_dx, end_dy, end_quadrant,
      input  ready
   );
   modport sink (
      input  valid, center_col, start_dx, start_dy, start_quadrant,
             end_dx, end_dy, end_quadrant,
      output ready
   );
endinterface

// ===== rtl/cara_rsp_if.sv =====
// Step result channel.
`timescale 1ns / 1ps

interface cara_rsp_if import cara_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic [CARA_COL_W-1:0]     out_center_col;
   logic [CARA_ROW_W-1:0]     out_center_row;
   logic [CARA_OUT_OFS_W-1:0] offset_a;
   logic [CARA_OUT_OFS_W-1:0] offset_b;
   logic [CARA_MASK_W-1:0]    draw_mask;
   logic                      last;

   modport source (
      output valid, out_center_col, out_center_row, offset_a, offset_b,
             draw_mask, last,
      input  ready
   );
   modport sink (
      input  valid, out_center_col, out_center_row, offset_a, offset_b,
             draw_mask, last,
      output ready
   );
endinterface

// ===== rtl/cara_csr_if.sv =====
// Register write channel.
`timescale 1ns / 1ps

interface cara_csr_if import cara_pkg::*; ();
   logic                     valid;
   logic                     ready;
   csr_index_type            index;
   logic [CARA_RADIUS_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/cara_ctrl.sv =====
// Controller of the arc rasterizer: command intake and step sequencing.
`timescale 1ns / 1ps

module cara_ctrl import cara_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  cara_sts_type sts,
   output cara_cmd_type cmd
);

   cara_state_type state_ff, state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CARA_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands: load a command when idle, step while the output slot frees
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         CARA_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = CARA_RUN;
            end
         end
         CARA_RUN: begin
            if (sts.out_free) begin
               cmd.step = 1'b1;
               if (sts.done) begin
                  state_in = CARA_IDLE;
               end
            end
         end
         default: begin
            state_in = CARA_IDLE;
         end
      endcase
   end

endmodule

// ===== rtl/cara_dpath.sv =====
// Datapath of the arc rasterizer: registers, midpoint step, arc mask and output stage.
`timescale 1ns / 1ps

module cara_dpath import cara_pkg::*; #(
   parameter int MAX_RADIUS = CARA_MAX_RADIUS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   cara_req_if.sink     req_chan,
   cara_rsp_if.source   rsp_chan,
   cara_csr_if.sink     csr_chan,
   input  cara_cmd_type cmd,
   output cara_sts_type sts
);

   // Largest radius the walk can see: register range clipped by the parameter
   localparam int RLIM_REG = (1 << CARA_RADIUS_W) - 1;
   localparam int RLIM     = (MAX_RADIUS < RLIM_REG) ? MAX_RADIUS : RLIM_REG;
   localparam int AW       = $clog2(RLIM + 2) + 1;
   localparam int DW       = AW + 3;
   localparam int CW       = (AW > CARA_OFS_W) ? AW : CARA_OFS_W;
   localparam int CNT_W    = $clog2(CARA_MAX_STEPS + 1);

   // Configuration registers
   logic [CARA_RADIUS_W-1:0] radius_ff;
   logic [CARA_ROW_W-1:0]    center_row_ff;

   // Arc command
   logic [CARA_COL_W-1:0]        col_ff;
   logic signed [CARA_OFS_W-1:0] sx_ff, sy_ff, ex_ff, ey_ff;
   logic [1:0]                   sq_ff, eq_ff;

   // Walk state
   logic signed [AW-1:0] a_ff, b_ff;
   logic signed [DW-1:0] dec_ff;
   logic [CNT_W-1:0]     cnt_ff;

   // Output stage
   logic                      rsp_valid_ff;
   logic [CARA_COL_W-1:0]     out_col_ff;
   logic [CARA_ROW_W-1:0]     out_row_ff;
   logic [CARA_OUT_OFS_W-1:0] out_a_ff, out_b_ff;
   logic [CARA_MASK_W-1:0]    out_mask_ff;
   logic                      out_last_ff;

   logic                 radius_sat;
   logic signed [AW-1:0] radius_sel;
   logic signed [DW-1:0] dec_init, a_ext, b_ext, dec_in;
   logic signed [AW-1:0] a_in, b_in;
   logic                 dec_neg;
   logic signed [CW-1:0] pa, pb;
   logic signed [CW-1:0] px [CARA_MASK_W];
   logic signed [CW-1:0] py [CARA_MASK_W];
   logic [CARA_MASK_W-1:0] mask;

   // Point-in-arc test for one reflected point
   function automatic logic in_arc(
      input logic signed [CW-1:0] dx,
      input logic signed [CW-1:0] dy,
      input logic signed [CW-1:0] sx,
      input logic signed [CW-1:0] sy,
      input logic [1:0]           sq,
      input logic signed [CW-1:0] ex,
      input logic signed [CW-1:0] ey,
      input logic [1:0]           eq
   );
      logic [1:0] q;
      logic dx_pos, dx_neg, dy_pos, dy_neg;
      logic right_half, top_half;
      logic xs, ys, xe, ye, start_ok, res;
      dx_neg = dx[CW-1];
      dy_neg = dy[CW-1];
      dx_pos = !dx[CW-1] && (dx != '0);
      dy_pos = !dy[CW-1] && (dy != '0);
      if (!dx_neg && dy_neg) begin
         q = CARA_QUAD_TR;
      end else if (dx_pos && !dy_neg) begin
         q = CARA_QUAD_BR;
      end else if (!dx_pos && dy_pos) begin
         q = CARA_QUAD_BL;
      end else begin
         q = CARA_QUAD_TL;
      end
      right_half = (q == CARA_QUAD_TR) || (q == CARA_QUAD_TL);
      top_half   = (q == CARA_QUAD_TR) || (q == CARA_QUAD_BR);
      xs = right_half ? (dx >= sx) : (dx <= sx);
      ys = top_half   ? (dy >= sy) : (dy <= sy);
      xe = right_half ? (dx <= ex) : (dx >= ex);
      ye = top_half   ? (dy <= ey) : (dy >= ey);
      start_ok = (q > sq) || ((q == sq) && xs && ys);
      if ((q > sq) && (q < eq)) begin
         res = 1'b1;
      end else if (!start_ok) begin
         res = 1'b0;
      end else if (q < eq) begin
         res = 1'b1;
      end else if (q == eq) begin
         res = xe && ye;
      end else begin
         res = 1'b0;
      end
      return res;
   endfunction

   // Accept every register write
   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff     <= CARA_RADIUS_RST;
         center_row_ff <= CARA_CENTER_ROW_RST;
      end else if (csr_chan.valid) begin
         case (csr_chan.index)
            CARA_CSR_RADIUS:     radius_ff     <= csr_chan.data;
            CARA_CSR_CENTER_ROW: center_row_ff <= csr_chan.data;
            default: begin
            end
         endcase
      end
   end

   // Saturate radius and form the starting decision value
   assign radius_sat = radius_ff > CARA_RADIUS_W'(RLIM);
   assign radius_sel = radius_sat ? AW'(RLIM) : AW'(radius_ff);
   assign dec_init   = DW'(CARA_DEC_INIT) - (DW'(radius_sel) <<< 1);

   // One midpoint step
   assign a_ext   = DW'(a_ff);
   assign b_ext   = DW'(b_ff);
   assign dec_neg = dec_ff[DW-1];
   assign dec_in  = dec_neg ? (dec_ff + (a_ext <<< 2) + DW'(CARA_DEC_INC_LOW))
                            : (dec_ff + ((a_ext - b_ext) <<< 2) + DW'(CARA_DEC_INC_HIGH));
   assign b_in    = dec_neg ? b_ff : (b_ff - AW'(1));
   assign a_in    = a_ff + AW'(1);

   assign sts.done     = (a_in > b_in) || (cnt_ff == CNT_W'(CARA_MAX_STEPS - 1));
   assign sts.out_free = !rsp_valid_ff || rsp_chan.ready;

   // Reflected points in mask bit order
   assign pa = CW'(a_ff);
   assign pb = CW'(b_ff);
   assign px[0] = pa;  assign py[0] = pb;
   assign px[1] = pa;  assign py[1] = -pb;
   assign px[2] = -pa; assign py[2] = pb;
   assign px[3] = -pa; assign py[3] = -pb;
   assign px[4] = -pb; assign py[4] = pa;
   assign px[5] = -pb; assign py[5] = -pa;
   assign px[6] = pb;  assign py[6] = pa;
   assign px[7] = pb;  assign py[7] = -pa;

   always_comb begin
      for (int k = 0; k < CARA_MASK_W; k++) begin
         mask[k] = in_arc(px[k], py[k], CW'(sx_ff), CW'(sy_ff), sq_ff,
                          CW'(ex_ff), CW'(ey_ff), eq_ff);
      end
   end

   // Capture the arc command
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         col_ff <= req_chan.center_col;
         sx_ff  <= req_chan.start_dx;
         sy_ff  <= req_chan.start_dy;
         sq_ff  <= req_chan.start_quadrant;
         ex_ff  <= req_chan.end_dx;
         ey_ff  <= req_chan.end_dy;
         eq_ff  <= req_chan.end_quadrant;
      end
   end

   // Initialize or advance the walk
   always_ff @(posedge clock) begin
      if (reset) begin
         a_ff   <= '0;
         b_ff   <= '0;
         dec_ff <= '0;
         cnt_ff <= '0;
      end else if (cmd.load) begin
         a_ff   <= '0;
         b_ff   <= radius_sel;
         dec_ff <= dec_init;
         cnt_ff <= '0;
      end else if (cmd.step) begin
         a_ff   <= a_in;
         b_ff   <= b_in;
         dec_ff <= dec_in;
         cnt_ff <= cnt_ff + CNT_W'(1);
      end
   end

   // Output stage: set on a step, drop after the transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.step) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.step) begin
         out_col_ff  <= col_ff;
         out_row_ff  <= center_row_ff;
         out_a_ff    <= CARA_OUT_OFS_W'(a_ff);
         out_b_ff    <= CARA_OUT_OFS_W'(b_ff);
         out_mask_ff <= mask;
         out_last_ff <= sts.done;
      end
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.out_center_col = out_col_ff;
   assign rsp_chan.out_center_row = out_row_ff;
   assign rsp_chan.offset_a       = out_a_ff;
   assign rsp_chan.offset_b       = out_b_ff;
   assign rsp_chan.draw_mask      = out_mask_ff;
   assign rsp_chan.last           = out_last_ff;

   // A step never overwrites a result that is still waiting
   assert property (@(posedge clock) disable iff (reset)
      cmd.step |-> (!rsp_valid_ff || rsp_chan.ready))
      else $error("step issued while output stage is occupied");

   // The walk only emits while a does not pass b
   assert property (@(posedge clock) disable iff (reset)
      cmd.step |-> (a_ff <= b_ff))
      else $error("step emitted with a beyond b");

   // The step count stays below the walk limit
   assert property (@(posedge clock) disable iff (reset)
      cmd.step |-> (cnt_ff < CNT_W'(CARA_MAX_STEPS)))
      else $error("walk exceeded the step limit");

   // A load restarts the walk at the top of the circle
   assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> (a_ff == '0 && cnt_ff == '0))
      else $error("walk not restarted after command load");

endmodule

// ===== rtl/circle_arc_rasterizer_unit.sv =====
// Sequence: a command transfer loads the walk; each step then registers one result.
// Throughput: one midpoint step per cycle, set by the single step unit of the
//   datapath; a stalled result output holds the walk. A command emits N results,
//   N the step count (about radius/sqrt(2) + 1, at most 46; 11 at radius 15).
// Reset: synchronous, active high; clears control, radius to 15, center row to 36.
`timescale 1ns / 1ps

module circle_arc_rasterizer_unit import cara_pkg::*; #(
   parameter int MAX_RADIUS = CARA_MAX_RADIUS_DEF
) (
   input logic        clock,
   input logic        reset,
   cara_req_if.sink   req_chan,
   cara_rsp_if.source rsp_chan,
   cara_csr_if.sink   csr_chan
);

   cara_cmd_type cmd;
   cara_sts_type sts;
   logic         req_ready;

   // Sequence command intake and steps
   cara_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   assign req_chan.ready = req_ready;

   // Walk the circle and build results
   cara_dpath #(
      .MAX_RADIUS (MAX_RADIUS)
   ) u_dpath (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan),
      .cmd      (cmd),
      .sts      (sts)
   );

endmodule
